FILE: rtl/pfmb_pkg.sv
// Shared types and constants of the polygon feather mesh builder.
package pfmb_pkg;

  localparam int unsigned MaxPolygonVertices = 64;
  localparam logic [16:0] OneQ16 = 17'h10000;

  // Register word addresses (paddr[3:2]).
  localparam logic [1:0] RegVertexCount   = 2'd0;
  localparam logic [1:0] RegFeatherLength = 2'd1;
  localparam logic [1:0] RegFeatherScale  = 2'd2;

  localparam logic [1:0] KindOuter    = 2'd0;
  localparam logic [1:0] KindInner    = 2'd1;
  localparam logic [1:0] KindTriangle = 2'd2;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [6:0]         vertex_slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               alpha;
    logic [6:0]         corner_a;
    logic [6:0]         corner_b;
    logic [6:0]         corner_c;
    logic               run_last;
  } out_word_t;

  typedef enum logic [3:0] {
    StIdle,
    StSquare,
    StSum,
    StRootGo,
    StRootWait,
    StDivGo,
    StDivWait,
    StScale,
    StMul,
    StEmit
  } state_e;

endpackage

FILE: rtl/pfmb_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
module pfmb_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] rad_q, rad_d;
  logic [34:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [34:0] rem_shift, trial;

  assign rem_shift = {rem_q[32:0], rad_q[63:62]};
  assign trial     = {1'b0, root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      // take two radicand bits, try the next root bit
      rad_d = {rad_q[61:0], 2'b00};
      if (rem_shift >= trial) begin
        rem_d  = rem_shift - trial;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_shift;
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: rtl/pfmb_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pfmb_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [32:0] quotient_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] dvd_q, dvd_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] rem_shift;

  assign rem_shift = {rem_q[31:0], dvd_q[32]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      quo_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[31:0], 1'b0};
      if (rem_shift >= {1'b0, dvs_q}) begin
        rem_d = rem_shift - {1'b0, dvs_q};
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = rem_shift;
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/polygon_feather_mesh_builder_top.sv
// Top level of the polygon feather mesh builder.
//
// Input channel: one word per polygon vertex (signed Q16.16 x and y), taken
// when in_valid_i is high and in_stall_o is low. The block holds in_stall_o
// high while it works on a vertex, so it takes one vertex at a time.
// Output channel: for vertex k it sends, in order, the outer vertex k, the
// inner vertex N+k, the fan triangle (only for k of 2 or more) and two rim
// triangles; the last word carries run_last. A word moves when out_valid_o is
// high and out_stall_i is low; a stalled word holds until taken.
// Each vertex passes through square, sum, bit-serial square root, restoring
// divide, scale and multiply before its words are emitted. A zero-length
// vertex skips the divide.
// Configuration: APB port, registers vertex_count, feather_length and
// feather_scale at byte addresses 0, 4 and 8; write only while idle.
// Reset: registers return to 3, 0.2 and 0.2, the vertex counter to zero and
// both channels go quiet.
module polygon_feather_mesh_builder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pfmb_pkg::in_word_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pfmb_pkg::out_word_t out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  pfmb_pkg::state_e state_q, state_d;

  // configuration registers
  logic [6:0]  vcount_q;
  logic [16:0] flen_q, fscale_q;
  logic        cfg_wr;

  // vertex counter and per-item context
  logic [5:0]  counter_q;
  logic [6:0]  n_q, k_q, next_q;
  logic [31:0] raw_x_q, raw_y_q, ax_q, ay_q;
  logic        nx_q, ny_q;
  logic [63:0] sqx_q, sqy_q, sum_q;
  logic [16:0] f_q, scale_q;
  logic [31:0] px_q, py_q;
  logic [2:0]  emit_q;

  // effective settings
  logic [6:0]  n_eff, k_eff, next_eff;
  logic [16:0] len_sat, lim_sat;
  logic        in_acc, out_acc, last_emit;

  logic        sqrt_start, sqrt_done, div_start, div_done;
  logic [31:0] root;
  logic [32:0] quo;
  logic [16:0] f_div;
  logic [48:0] prod_x, prod_y;
  logic [31:0] mag_x, mag_y;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      pfmb_pkg::RegVertexCount:   prdata = {25'd0, vcount_q};
      pfmb_pkg::RegFeatherLength: prdata = {15'd0, flen_q};
      pfmb_pkg::RegFeatherScale:  prdata = {15'd0, fscale_q};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 7'd3;
      flen_q   <= 17'd13107;
      fscale_q <= 17'd13107;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        pfmb_pkg::RegVertexCount:   vcount_q <= pwdata[6:0];
        pfmb_pkg::RegFeatherLength: flen_q   <= pwdata[16:0];
        pfmb_pkg::RegFeatherScale:  fscale_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // clamp the count, fold a stale counter back to zero
  always_comb begin
    if (vcount_q < 7'd3) begin
      n_eff = 7'd3;
    end else if (vcount_q > 7'(pfmb_pkg::MaxPolygonVertices)) begin
      n_eff = 7'(pfmb_pkg::MaxPolygonVertices);
    end else begin
      n_eff = vcount_q;
    end
    k_eff    = ({1'b0, counter_q} >= n_eff) ? 7'd0 : {1'b0, counter_q};
    next_eff = (k_eff + 7'd1 >= n_eff) ? 7'd0 : k_eff + 7'd1;
    len_sat  = (flen_q > pfmb_pkg::OneQ16) ? pfmb_pkg::OneQ16 : flen_q;
    lim_sat  = (fscale_q > pfmb_pkg::OneQ16) ? pfmb_pkg::OneQ16 : fscale_q;
  end

  assign in_acc    = in_valid_i & ~in_stall_o;
  assign out_acc   = out_valid_o & ~out_stall_i;
  assign last_emit = (emit_q == 3'd4);

  pfmb_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sum_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  pfmb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({len_sat, 16'd0}),
    .divisor_i  (root),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign f_div = (quo > {16'd0, lim_sat}) ? lim_sat : quo[16:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfmb_pkg::StIdle:     if (in_acc) state_d = pfmb_pkg::StSquare;
      pfmb_pkg::StSquare:   state_d = pfmb_pkg::StSum;
      pfmb_pkg::StSum:      state_d = pfmb_pkg::StRootGo;
      pfmb_pkg::StRootGo:   state_d = pfmb_pkg::StRootWait;
      pfmb_pkg::StRootWait: begin
        if (sqrt_done) begin
          state_d = (root == '0) ? pfmb_pkg::StScale : pfmb_pkg::StDivGo;
        end
      end
      pfmb_pkg::StDivGo:    state_d = pfmb_pkg::StDivWait;
      pfmb_pkg::StDivWait:  if (div_done) state_d = pfmb_pkg::StScale;
      pfmb_pkg::StScale:    state_d = pfmb_pkg::StMul;
      pfmb_pkg::StMul:      state_d = pfmb_pkg::StEmit;
      pfmb_pkg::StEmit:     if (out_acc && last_emit) state_d = pfmb_pkg::StIdle;
      default:              state_d = pfmb_pkg::StIdle;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o  = (state_q != pfmb_pkg::StIdle);
    out_valid_o = (state_q == pfmb_pkg::StEmit);
    sqrt_start  = (state_q == pfmb_pkg::StRootGo);
    div_start   = (state_q == pfmb_pkg::StDivGo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pfmb_pkg::StIdle;
      counter_q <= '0;
      emit_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == pfmb_pkg::StMul) begin
        emit_q <= '0;
      end else if (out_acc) begin
        // skip the fan triangle for the first two vertices
        emit_q <= (emit_q == 3'd1 && k_q < 7'd2) ? 3'd3 : emit_q + 3'd1;
        if (last_emit) counter_q <= next_q[5:0];
      end
    end
  end

  assign mag_x  = nx_q ? (32'd0 - raw_x_q) : raw_x_q;
  assign mag_y  = ny_q ? (32'd0 - raw_y_q) : raw_y_q;
  assign prod_x = ax_q * scale_q + 49'd32768;
  assign prod_y = ay_q * scale_q + 49'd32768;

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_x_q <= in_word_i.vertex_x;
      raw_y_q <= in_word_i.vertex_y;
      nx_q    <= in_word_i.vertex_x[31];
      ny_q    <= in_word_i.vertex_y[31];
      n_q     <= n_eff;
      k_q     <= k_eff;
      next_q  <= next_eff;
    end
    if (state_q == pfmb_pkg::StSquare) begin
      ax_q  <= mag_x;
      ay_q  <= mag_y;
      sqx_q <= mag_x * mag_x;
      sqy_q <= mag_y * mag_y;
    end
    if (state_q == pfmb_pkg::StSum) sum_q <= sqx_q + sqy_q;
    if (state_q == pfmb_pkg::StRootWait && sqrt_done) f_q <= lim_sat;
    if (state_q == pfmb_pkg::StDivWait && div_done) f_q <= f_div;
    if (state_q == pfmb_pkg::StScale) scale_q <= pfmb_pkg::OneQ16 - f_q;
    if (state_q == pfmb_pkg::StMul) begin
      px_q <= nx_q ? (32'd0 - prod_x[47:16]) : prod_x[47:16];
      py_q <= ny_q ? (32'd0 - prod_y[47:16]) : prod_y[47:16];
    end
  end

  // build the word for the current emit step
  always_comb begin
    out_word_o          = '0;
    out_word_o.run_last = last_emit;
    case (emit_q)
      3'd0: begin
        out_word_o.result_kind = pfmb_pkg::KindOuter;
        out_word_o.vertex_slot = k_q;
        out_word_o.pos_x       = raw_x_q;
        out_word_o.pos_y       = raw_y_q;
      end
      3'd1: begin
        out_word_o.result_kind = pfmb_pkg::KindInner;
        out_word_o.vertex_slot = n_q + k_q;
        out_word_o.pos_x       = px_q;
        out_word_o.pos_y       = py_q;
        out_word_o.alpha       = 1'b1;
      end
      3'd2: begin
        out_word_o.result_kind = pfmb_pkg::KindTriangle;
        out_word_o.corner_a    = n_q;
        out_word_o.corner_b    = n_q + k_q - 7'd1;
        out_word_o.corner_c    = n_q + k_q;
      end
      3'd3: begin
        out_word_o.result_kind = pfmb_pkg::KindTriangle;
        out_word_o.corner_a    = k_q;
        out_word_o.corner_b    = next_q;
        out_word_o.corner_c    = n_q + k_q;
      end
      3'd4: begin
        out_word_o.result_kind = pfmb_pkg::KindTriangle;
        out_word_o.corner_a    = n_q + k_q;
        out_word_o.corner_b    = next_q;
        out_word_o.corner_c    = n_q + next_q;
      end
      default: out_word_o.run_last = 1'b0;
    endcase
  end

endmodule
